// ===== rtl/wildcard_byte_pattern_scanner_assert.svh =====
// Assertion macros for the wildcard byte pattern scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property at each clock edge outside reset.
`define WBPS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wbps assertion failed");

// Check a property at every clock edge, reset included.
`define WBPS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wbps assertion failed");

`else

`define WBPS_ASSERT(label, clk, rst, prop)
`define WBPS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/wbps_pkg.sv =====
// Shared constants and register codes for the wildcard byte pattern scanner.
package wbps_pkg;

  // Pattern storage: sixteen bytes, split over two 64-bit registers
  localparam int PAT_BYTES        = 16;
  localparam int MAX_PATTERN_DEF  = 16;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_INDEX_W      = 3;
  localparam int LEN_W            = 5;
  localparam int MODE_W           = 2;
  localparam int CAP_W            = 4;
  localparam int OFFSET_W         = 16;
  localparam int ADDR_W           = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RESULT_MODE      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_POSITION = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RESULT_OFFSET    = 3'd6;

  // Result modes; the unused code falls back to match start
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORD  = 2'd2;

endpackage

// ===== rtl/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner: window, compare and result register.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  input    in         in_valid / in_stall  mem_byte, mem_address, restart
//  result   out        out_valid/out_stall  found_value
//  config   in         cfg_write_enable     cfg_index, cfg_data
//
// One byte is taken per cycle unless in_stall is high; a match passes from the
// window, updated at its byte transfer, through the compare stage into the result
// register, which drives found_value.
// The compare stage holds one byte; the input stalls only while that byte has
// hit and the result register is full and stalled.
// Synchronous reset empties both stages and clears the window fill count.
`include "wildcard_byte_pattern_scanner_assert.svh"

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // byte input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             mem_byte,
  input  logic [ADDR_W-1:0]      mem_address,
  input  logic                   restart,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ADDR_W-1:0]      found_value,
  // configuration writes
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_LIMIT = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;
  localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);

  // Configuration registers
  logic [63:0]         pattern_low;
  logic [63:0]         pattern_high;
  logic [PAT_BYTES-1:0] wildcard_mask;
  logic [LEN_W-1:0]    pattern_length;
  logic [MODE_W-1:0]   result_mode;
  logic [CAP_W-1:0]    capture_position;
  logic [OFFSET_W-1:0] result_offset;

  // Window and compare stage
  logic [7:0]          window [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0]   fill_count;
  logic                s1_valid;
  logic [ADDR_W-1:0]   s1_addr;

  logic                in_xfer;
  logic                s1_hit;
  logic                s1_move;
  logic [ADDR_W-1:0]   s1_value;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low      <= '0;
      pattern_high     <= '0;
      wildcard_mask    <= '0;
      pattern_length   <= LEN_W'(1);
      result_mode      <= MODE_START;
      capture_position <= '0;
      result_offset    <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_PATTERN_LOW:      pattern_low      <= cfg_data;
        REG_PATTERN_HIGH:     pattern_high     <= cfg_data;
        REG_WILDCARD_MASK:    wildcard_mask    <= cfg_data[PAT_BYTES-1:0];
        REG_PATTERN_LENGTH:   pattern_length   <= cfg_data[LEN_W-1:0];
        REG_RESULT_MODE:      result_mode      <= cfg_data[MODE_W-1:0];
        REG_CAPTURE_POSITION: capture_position <= cfg_data[CAP_W-1:0];
        REG_RESULT_OFFSET:    result_offset    <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer and stall
  assign in_xfer  = in_valid && !in_stall;
  assign s1_move  = s1_valid && (!s1_hit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  // Shift the window; restart clears the older bytes
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      window[0] <= mem_byte;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
        window[i] <= restart ? 8'h00 : window[i-1];
      end
    end
  end

  // Fill count saturates at the window depth
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (in_xfer) begin
      if (restart) begin
        fill_count <= FILL_W'(1);
      end else if (fill_count != FILL_W'(MAX_PATTERN_BYTES)) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // Compare stage holds the address of the newest byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr <= mem_address;
    end
  end

  // Newest sixteen bytes, zero past the window depth
  logic [7:0] near [PAT_BYTES];

  for (genvar g = 0; g < PAT_BYTES; g++) begin : g_near
    if (g < MAX_PATTERN_BYTES) begin : g_real
      assign near[g] = window[g];
    end else begin : g_pad
      assign near[g] = 8'h00;
    end
  end

  // Effective length: zero acts as one, clamp to the limit
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(LEN_LIMIT)) begin
      len_eff = LEN_W'(LEN_LIMIT);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Match for every candidate length, then pick the configured one
  logic [8*PAT_BYTES-1:0] pat_vec;
  logic [PAT_BYTES-1:0]   hit_by_len;
  logic [CAP_W-1:0]       len_sel;
  logic                   window_full;

  assign pat_vec = {pattern_high, pattern_low};

  always_comb begin
    for (int l = 1; l <= PAT_BYTES; l++) begin
      hit_by_len[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (!wildcard_mask[k] && (near[l-1-k] != pat_vec[8*k +: 8])) begin
          hit_by_len[l-1] = 1'b0;
        end
      end
    end
  end

  assign len_sel     = CAP_W'(len_eff - LEN_W'(1));
  assign window_full = 32'(fill_count) >= 32'(len_eff);
  assign s1_hit      = window_full && hit_by_len[len_sel];

  // Captured word: reverse the bytes so that one right shift aligns it
  logic [8*PAT_BYTES-1:0] rev_vec;
  logic [8*PAT_BYTES-1:0] rev_shift;
  logic [5:0]             cap_shift;
  logic [ADDR_W-1:0]      cap_word;

  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      rev_vec[8*j +: 8] = near[PAT_BYTES-1-j];
    end
  end

  assign cap_shift = 6'(PAT_BYTES) - {1'b0, len_eff} + {2'b00, capture_position};
  assign rev_shift = rev_vec >> {cap_shift, 3'b000};
  assign cap_word  = rev_shift[ADDR_W-1:0];

  // Select the result and add the sign-extended offset
  logic [ADDR_W-1:0] base_value;

  always_comb begin
    case (result_mode)
      MODE_END:  base_value = s1_addr + ADDR_W'(1);
      MODE_WORD: base_value = cap_word;
      default:   base_value = s1_addr - ADDR_W'(len_eff) + ADDR_W'(1);
    endcase
  end

  assign s1_value = base_value + {{(ADDR_W-OFFSET_W){result_offset[OFFSET_W-1]}}, result_offset};

  // Result register: load on a hit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_hit) begin
      found_value <= s1_value;
    end
  end

  // Assertions
  `WBPS_ASSERT(a_stall_needs_stage, clk, rst, in_stall |-> (s1_valid && s1_hit && out_valid))
  `WBPS_ASSERT(a_xfer_fills_stage, clk, rst, in_xfer |=> s1_valid)
  `WBPS_ASSERT(a_restart_fill_one, clk, rst, (in_xfer && restart) |=> (fill_count == FILL_W'(1)))
  `WBPS_ASSERT(a_result_from_hit, clk, rst, $rose(out_valid) |-> $past(s1_move && s1_hit))
  `WBPS_ASSERT_ALWAYS(a_fill_bound, clk, rst || (32'(fill_count) <= MAX_PATTERN_BYTES))

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the wildcard byte pattern scanner: random traffic and predictor.
module testbench;
  import wbps_pkg::*;

  // Literal bytes that once served as wildcards; they must now compare as data
  localparam logic [7:0] QMARK_BYTE = 8'h3F;
  localparam logic [7:0] X_BYTE     = 8'h58;

  // Track scanner state and hold the found values still owed by the block
  class match_scoreboard;
    logic [63:0]       pat_low;
    logic [63:0]       pat_high;
    logic [15:0]       wild_mask;
    logic [4:0]        len_reg;
    logic [1:0]        mode_reg;
    logic [3:0]        cap_reg;
    logic [15:0]       offset_reg;
    logic [7:0]        window_bytes [PAT_BYTES];
    int                fill;
    logic [ADDR_W-1:0] expected_hits [$];
    int                errors;
    int                hits_checked;

    function new();
      pat_low = '0;
      pat_high = '0;
      wild_mask = '0;
      len_reg = 5'd1;
      mode_reg = MODE_START;
      cap_reg = '0;
      offset_reg = '0;
      foreach (window_bytes[k]) window_bytes[k] = '0;
      fill = 0;
      errors = 0;
      hits_checked = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PATTERN_LOW:      pat_low = data;
        REG_PATTERN_HIGH:     pat_high = data;
        REG_WILDCARD_MASK:    wild_mask = data[15:0];
        REG_PATTERN_LENGTH:   len_reg = data[LEN_W-1:0];
        REG_RESULT_MODE:      mode_reg = data[MODE_W-1:0];
        REG_CAPTURE_POSITION: cap_reg = data[CAP_W-1:0];
        REG_RESULT_OFFSET:    offset_reg = data[OFFSET_W-1:0];
        default: ;
      endcase
    endfunction

    // Shift the byte into the window and queue a found value on a match
    function void note_byte(logic [7:0] b, logic [ADDR_W-1:0] addr, logic rs);
      logic [127:0]      pattern;
      logic [ADDR_W-1:0] value;
      logic [ADDR_W-1:0] owed;
      int                eff;
      int                p;
      pattern = {pat_high, pat_low};
      if (rs) begin
        foreach (window_bytes[k]) window_bytes[k] = '0;
        fill = 0;
      end
      for (int k = PAT_BYTES - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
      window_bytes[0] = b;
      if (fill < PAT_BYTES) fill++;
      // zero length acts as one, oversized lengths clamp to the window
      eff = (len_reg == 0) ? 1 : ((len_reg > PAT_BYTES) ? PAT_BYTES : len_reg);
      if (fill < eff) return;
      for (int k = 0; k < eff; k++) begin
        if (!wild_mask[k] && window_bytes[eff-1-k] != pattern[8*k +: 8]) return;
      end
      case (mode_reg)
        MODE_END: value = addr + 1;
        MODE_WORD: begin
          // bytes past the pattern end read as zero
          value = '0;
          for (int k = 0; k < 4; k++) begin
            p = cap_reg + k;
            if (p < eff) value[8*k +: 8] = window_bytes[eff-1-p];
          end
        end
        default: value = addr - (eff - 1);
      endcase
      owed = value + {{16{offset_reg[15]}}, offset_reg};
      expected_hits = {expected_hits, owed};
    endfunction

    function void check_result(logic [ADDR_W-1:0] got);
      logic [ADDR_W-1:0] want;
      if (expected_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("found_value %h with no match pending", got);
        return;
      end
      want = expected_hits.pop_front();
      hits_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("found_value mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             mem_byte = '0;
  logic [ADDR_W-1:0]      mem_address = '0;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ADDR_W-1:0]      found_value;
  logic                   cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  match_scoreboard sb = new();

  // Stimulus state: the pattern in force and the next scan address
  logic [127:0]      cur_pattern = '0;
  logic [15:0]       cur_mask = '0;
  int                cur_len = 1;
  logic [ADDR_W-1:0] next_addr = '0;
  bit                calm = 1'b0;
  int                items_issued = 0;
  int                settings_done = 0;

  wildcard_byte_pattern_scanner i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mem_byte(mem_byte),
    .mem_address(mem_address),
    .restart(restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found_value(found_value),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Observe register writes and both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write_enable) sb.write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_byte(mem_byte, mem_address, restart);
      if (out_valid && !out_stall) sb.check_result(found_value);
    end
  end

  // Stall the result channel in random bursts unless the phase is calm
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  // Write every register; narrow ones carry random junk above their width
  task automatic apply_setting(logic [63:0] pl, logic [63:0] ph, logic [15:0] mask,
                               logic [4:0] len, logic [1:0] mode, logic [3:0] cap,
                               logic [15:0] off);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    set_register(REG_PATTERN_LOW, pl);
    set_register(REG_PATTERN_HIGH, ph);
    set_register(REG_WILDCARD_MASK, {junk[63:16], mask});
    set_register(REG_PATTERN_LENGTH, {junk[63:LEN_W], len});
    set_register(REG_RESULT_MODE, {junk[63:MODE_W], mode});
    set_register(REG_CAPTURE_POSITION, {junk[63:CAP_W], cap});
    set_register(REG_RESULT_OFFSET, {junk[63:16], off});
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    cur_pattern = {ph, pl};
    cur_mask = mask;
    cur_len = (len == 0) ? 1 : ((len > PAT_BYTES) ? PAT_BYTES : len);
    settings_done++;
  endtask

  // Offer one byte, with an optional idle burst first, and wait for its transfer
  task automatic send_byte(logic [7:0] b, logic rs);
    if (!calm && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mem_byte <= b;
    mem_address <= next_addr;
    restart <= rs;
    next_addr = next_addr + 1;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_issued++;
  endtask

  // Send one copy of the current pattern, random bytes at wildcards, maybe corrupted
  task automatic send_copy(logic rs, logic broken);
    int         bad;
    logic [7:0] b;
    bad = broken ? $urandom_range(0, cur_len - 1) : -1;
    for (int k = 0; k < cur_len; k++) begin
      b = cur_mask[k] ? 8'($urandom) : cur_pattern[8*k +: 8];
      if (k == bad) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, rs && k == 0);
    end
  endtask

  // Drop valid, wait for the owed results, then let the compare stage empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int n = 0; n < 300 && sb.expected_hits.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] mask;
    logic [4:0]  len;
    logic [15:0] off;
    int          phase_end;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: one-byte zero pattern, start address, zero offset
    next_addr = 32'h0;
    send_byte(8'h00, 1'b1);
    next_addr = 32'hFFFF_FFFF;
    send_byte(8'hFF, 1'b0);
    drain();

    // Literal question mark and X bytes, end address wrapping, top offset
    apply_setting({32'h0, 8'hFF, 8'h12, X_BYTE, QMARK_BYTE}, '1, 16'h0000, 5'd4,
                  MODE_END, 4'd0, 16'h7FFF);
    next_addr = 32'hFFFF_FFFC;
    send_byte(QMARK_BYTE, 1'b1);
    send_byte(X_BYTE, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(QMARK_BYTE, 1'b0);
    send_byte(X_BYTE, 1'b0);
    drain();

    // Zero length acts as one; capture past the end reads zero; lowest offset
    apply_setting('1, '1, 16'hFFFF, 5'd0, MODE_WORD, 4'd15, 16'h8000);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain();

    // Oversized length clamps to sixteen; the unused mode reports the start
    apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom) & 16'($urandom),
                  5'd31, 2'd3, 4'd12, 16'h0000);
    next_addr = $urandom;
    send_copy(1'b1, 1'b0);
    drain();

    // Random settings, each followed by a stream of pattern copies and noise
    while (items_issued < 1000) begin
      calm = (items_issued > 850) || ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0: mask = 16'h0000;
        1: mask = 16'hFFFF;
        2: mask = 16'($urandom);
        default: mask = 16'($urandom) & 16'($urandom);
      endcase
      if ($urandom_range(0, 7) == 0)
        len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
      else
        len = 5'($urandom_range(1, 16));
      case ($urandom_range(0, 5))
        0: off = 16'h8000;
        1: off = 16'h7FFF;
        default: off = 16'($urandom);
      endcase
      apply_setting({$urandom, $urandom}, {$urandom, $urandom}, mask, len,
                    2'($urandom), 4'($urandom), off);
      next_addr = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                              : $urandom;
      phase_end = items_issued + $urandom_range(30, 70);
      while (items_issued < phase_end) begin
        if ($urandom_range(0, 9) < 7)
          send_copy($urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        else
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 49) == 0);
      end
      drain();
    end

    if (sb.expected_hits.size() != 0) begin
      sb.errors++;
      $display("%0d expected found values never arrived", sb.expected_hits.size());
    end
    $display("Scanned %0d bytes under %0d register settings; %0d matches compared.",
             items_issued, settings_done, sb.hits_checked);
    if (sb.errors == 0) begin
      $display("wildcard_byte_pattern_scanner verification clean");
    end else begin
      $display("wildcard_byte_pattern_scanner verification failed");
    end
    $finish;
  end

  // Bound the run in case a handshake never completes
  initial begin
    #4_000_000;
    $display("wildcard_byte_pattern_scanner verification failed");
    $finish;
  end

endmodule
